[rtl/core/assert_macros.svh]
// Assertion macros shared by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// Package: geometry, codes, tables and types of the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_STOP  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_N  = (ROWS - 1) * COLUMNS;

    // Widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int POS_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    // Commands
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Cell values
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [CELL_W-1:0] TEXT_ATTR  = 16'h0F00;

    // Next tab stop for every column, built at elaboration
    typedef logic [COLX_W-1:0] tab_table_t [COLUMNS];

    function automatic tab_table_t tab_table_f();
        tab_table_t t;
        for (int i = 0; i < COLUMNS; i++) begin
            t[i] = COLX_W'(i + TAB_STOP - (i % TAB_STOP));
        end
        return t;
    endfunction

    localparam tab_table_t TAB_NEXT = tab_table_f();

    // Cursor update for one put
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             wr_en;
        logic             scroll;
    } cursor_upd_t;

endpackage

[rtl/core/tcw_cursor_next.sv]
// Cursor update logic for one put word: control codes, wrap and scroll detect.
module tcw_cursor_next (
    input  logic [tcw_pkg::COL_W-1:0] col,
    input  logic [tcw_pkg::ROW_W-1:0] row,
    input  logic [7:0]                char_code,
    output tcw_pkg::cursor_upd_t      upd
);

    logic [tcw_pkg::COLX_W-1:0] col_x;
    logic                       row_inc;
    logic [tcw_pkg::ROW_W:0]    row_x;
    logic                       printable;

    assign printable = (char_code >= tcw_pkg::CH_SPACE) && (char_code <= tcw_pkg::CH_DEL);

    // Decode the byte, then wrap the column and detect a scroll
    always_comb
    begin
        col_x   = tcw_pkg::COLX_W'(col);
        row_inc = 1'b0;
        case (char_code)
            tcw_pkg::CH_BS:
            begin
                if (col != '0)
                    col_x = tcw_pkg::COLX_W'(col) - tcw_pkg::COLX_W'(1);
            end
            tcw_pkg::CH_TAB:
            begin
                col_x = tcw_pkg::TAB_NEXT[col];
            end
            tcw_pkg::CH_CR:
            begin
                col_x = '0;
            end
            tcw_pkg::CH_LF:
            begin
                col_x   = '0;
                row_inc = 1'b1;
            end
            default:
            begin
                if (printable)
                    col_x = tcw_pkg::COLX_W'(col) + tcw_pkg::COLX_W'(1);
            end
        endcase

        if (col_x >= tcw_pkg::COLX_W'(tcw_pkg::COLUMNS))
        begin
            col_x   = '0;
            row_inc = 1'b1;
        end

        row_x = {1'b0, row} + {{tcw_pkg::ROW_W{1'b0}}, row_inc};

        upd.wr_en  = printable;
        upd.col    = col_x[tcw_pkg::COL_W-1:0];
        upd.scroll = (row_x >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
        upd.row    = upd.scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                : row_x[tcw_pkg::ROW_W-1:0];
    end

endmodule

[rtl/core/tcw_screen_mem.sv]
// Screen cell memory: one write port, one registered read port.
module tcw_screen_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [tcw_pkg::ADDR_W-1:0]  waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [tcw_pkg::ADDR_W-1:0]  raddr,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::CELL_COUNT];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            cells[waddr] <= wdata;
    end

    // Read port, registered, with read enable
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= cells[raddr];
    end

endmodule

[rtl/core/text_mode_console_writer.sv]
// Top level: text console writer sequencer around the screen memory.
//
//   channel   | handshake           | words
//   ----------+---------------------+--------------------------------
//   command   | start, busy         | cmd, char_code, cell_index
//   result    | done (1-cycle pulse)| cursor_pos, cell_data
//
// A word is taken when start is high and busy is low; its result pulses on
// done in the cycle after the work ends. A plain put or unused command ends in
// the cycle it is taken, a read waits on the registered memory read, a clear
// blanks every cell with one blank write a cycle. A put that scrolls copies the
// SCROLL_N cells below row 0 up one row, then makes COLUMNS blank writes, through
// the single memory write port. After reset busy stays high while the screen is
// blanked. The receiver cannot stall; a result is held only for its done cycle.
`include "assert_macros.svh"

module text_mode_console_writer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [7:0]                   char_code,
    input  logic [tcw_pkg::IDX_W-1:0]    cell_index,
    output logic                         done,
    output logic [tcw_pkg::POS_W-1:0]    cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]   cell_data
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [tcw_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [tcw_pkg::COL_W-1:0]      col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                           done_reg, done_next;
    logic [tcw_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [tcw_pkg::CELL_W-1:0]     data_reg, data_next;
    logic                           rd_ok_reg, rd_ok_next;

    logic                           mem_we;
    logic [tcw_pkg::ADDR_W-1:0]     mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
    logic                           mem_re;
    logic [tcw_pkg::ADDR_W-1:0]     mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_rdata;

    tcw_pkg::cursor_upd_t           upd;
    logic [tcw_pkg::ADDR_W-1:0]     cur_addr;
    logic                           accept;
    logic                           idx_ok;

    tcw_cursor_next u_cursor (
        .col       (col_reg),
        .row       (row_reg),
        .char_code (char_code),
        .upd       (upd)
    );

    tcw_screen_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign idx_ok = ({21'd0, cell_index} < 32'(tcw_pkg::CELL_COUNT));

    assign cur_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_reg) *
                      tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col_reg));

    // Sequence commands, sweeps and the scroll copy
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        done_next  = 1'b0;
        data_next  = '0;
        rd_ok_next = rd_ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[tcw_pkg::ADDR_W-1:0];
        mem_wdata  = tcw_pkg::BLANK_CELL;
        mem_re     = 1'b0;
        mem_raddr  = tcw_pkg::ADDR_W'(cell_index);

        case (state_reg)
            S_INIT, S_FILL:
            begin
                // blank one cell a cycle
                mem_we = 1'b1;
                if (cnt_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                    done_next  = (state_reg == S_FILL);
                end
                else
                    cnt_next = cnt_reg + tcw_pkg::CNT_W'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        tcw_pkg::CMD_PUT:
                        begin
                            col_next  = upd.col;
                            row_next  = upd.row;
                            mem_we    = upd.wr_en;
                            mem_waddr = cur_addr;
                            mem_wdata = tcw_pkg::TEXT_ATTR | {8'd0, char_code};
                            if (upd.scroll)
                            begin
                                state_next = S_SCROLL;
                                cnt_next   = '0;
                            end
                            else
                                done_next = 1'b1;
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = S_FILL;
                            cnt_next   = '0;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = idx_ok;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCROLL:
            begin
                // read one row ahead, write the cell fetched last cycle
                if (cnt_reg < tcw_pkg::CNT_W'(tcw_pkg::SCROLL_N))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = tcw_pkg::ADDR_W'(cnt_reg + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tcw_pkg::ADDR_W'(cnt_reg - tcw_pkg::CNT_W'(1));
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == tcw_pkg::CNT_W'(tcw_pkg::SCROLL_N))
                    state_next = S_FILL;
                else
                    cnt_next = cnt_reg + tcw_pkg::CNT_W'(1);
            end
            S_READ:
            begin
                done_next  = 1'b1;
                data_next  = rd_ok_reg ? mem_rdata : '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pos_next = tcw_pkg::POS_W'(tcw_pkg::ADDR_W'(row_next) *
                   tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col_next));
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        data_reg  <= data_next;
        rd_ok_reg <= rd_ok_next;
    end

    assign done       = done_reg;
    assign cursor_pos = pos_reg;
    assign cell_data  = data_reg;

    `ASSERT_NEXT(a_accept_progress, accept, busy || done, "accepted word neither in work nor done")
    `ASSERT_IMPL(a_col_range, 1'b1, int'(col_reg) < tcw_pkg::COLUMNS, "cursor column out of range")
    `ASSERT_IMPL(a_scroll_row, state_reg == S_SCROLL, row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1), "scroll with cursor off last row")
    `ASSERT_IMPL(a_done_idle, done, !(state_reg == S_SCROLL) && !(state_reg == S_INIT), "result during scroll or init")

endmodule
